[hdl/assert_macros.svh]
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked at every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/brd_pkg.sv]
// shared types and constants for the breathing rate detector
package brd_pkg;

    localparam int WINDOW_SIZE_DEF = 64;

    localparam int SAMPLE_W = 16;
    localparam int GAP_W    = 15;
    localparam int RATE_Q_W = 12;
    localparam int SQ_W     = 31;
    localparam int SSB_W    = 16;
    localparam int RATE_W   = 22;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HALF_GAP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE  = 1'd1;

    localparam logic [GAP_W-1:0]    MIN_HALF_GAP_RST = 15'd164;
    localparam logic [RATE_Q_W-1:0] SAMPLE_RATE_RST  = 12'd200;

    typedef enum logic [1:0] {
        TAG_ABSENT = 2'd0,
        TAG_POS    = 2'd1,
        TAG_NEG    = 2'd2
    } tag_t;

    typedef enum logic [2:0] {
        ST_UNKNOWN     = 3'd0,
        ST_LOW         = 3'd1,
        ST_HIGH        = 3'd2,
        ST_MID_RISING  = 3'd3,
        ST_MID_FALLING = 3'd4,
        ST_MID_UNKNOWN = 3'd5
    } band_t;

    // front to back queue entry: one sample with its present flag
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       present;
    } work_t;

    typedef struct packed {
        logic [14:0]  upper_level;
        logic [15:0]  lower_level;
        logic         upper_present;
        logic         lower_present;
        logic [2:0]   band_state;
        logic [RATE_W-1:0] rate_bpm;
        logic         rate_present;
        logic         breath_detected;
    } result_t;

endpackage

[hdl/brd_ram.sv]
// generic single-port ram with registered read
module brd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[hdl/brd_front.sv]
// input stage: accepts samples into a two-entry queue
module brd_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  brd_pkg::work_t        in_item,
    output logic                  q_valid,
    input  logic                  q_take,
    output brd_pkg::work_t        q_item
);

    brd_pkg::work_t slot_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       wr_reg;
    logic       push;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = slot_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (q_take)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_take};
        end
    end

endmodule

[hdl/brd_back.sv]
// window update, rms levels, hysteresis machine and rate division
module brd_back #(
    parameter int WINDOW_SIZE = brd_pkg::WINDOW_SIZE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_take,
    input  brd_pkg::work_t                q_item,
    input  logic [brd_pkg::GAP_W-1:0]     min_half_gap,
    input  logic [brd_pkg::RATE_Q_W-1:0]  sample_rate_q4,
    output logic                          res_valid,
    input  logic                          res_ready,
    output brd_pkg::result_t              res
);

    localparam int AW  = $clog2(WINDOW_SIZE);
    localparam int CW  = $clog2(WINDOW_SIZE + 1);
    localparam int SW  = brd_pkg::SQ_W + CW;
    localparam int RW  = 20;
    localparam int DVW = SW;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_READ  = 8'b0000_0010,
        S_UPD   = 8'b0000_0100,
        S_DIV   = 8'b0000_1000,
        S_SQRT  = 8'b0001_0000,
        S_MACH  = 8'b0010_0000,
        S_RATE  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [AW-1:0]        slot_reg;
    logic [CW-1:0]        fill_reg;
    logic [SW-1:0]        psum_reg, nsum_reg;
    logic [CW-1:0]        pcnt_reg, ncnt_reg;
    brd_pkg::band_t       band_reg;
    logic [brd_pkg::SSB_W-1:0] ssb_reg;
    logic                 trusted_reg;
    logic [brd_pkg::RATE_W-1:0] rate_reg;
    logic                 rate_ok_reg;

    brd_pkg::work_t       item_reg;
    logic [brd_pkg::SQ_W-1:0] sq_reg;
    logic [brd_pkg::SQ_W-1:0] old_sq;
    logic                 pass_reg;  // 0 upper, 1 lower
    logic [14:0]          ut_reg;
    logic [15:0]          lt_mag_reg;

    // shared restoring divider
    logic [DVW-1:0] num_reg;
    logic [DVW-1:0] den_reg;
    logic [DVW-1:0] rem_reg;
    logic [DVW-1:0] quo_reg;
    logic [5:0]     step_reg;

    // shared square root
    logic [31:0] rv_reg;
    logic [31:0] rres_reg;
    logic [31:0] rbit_reg;

    brd_pkg::result_t res_reg;
    logic             res_valid_reg;
    logic             breath_reg;

    logic sq_we;
    logic up_ok, lo_ok;
    logic signed [17:0] x_s, ut_s, lt_s;
    logic [brd_pkg::SQ_W+1:0] ring_wdata, ring_rdata;
    brd_pkg::tag_t new_tag, old_tag;
    logic out_load;

    // each ring word holds the sign tag above the square
    assign sq_we      = (state_reg == S_READ);
    assign new_tag    = !item_reg.present ? brd_pkg::TAG_ABSENT
                      : (item_reg.sample[brd_pkg::SAMPLE_W-1] ? brd_pkg::TAG_NEG
                                                               : brd_pkg::TAG_POS);
    assign ring_wdata = {new_tag, sq_reg};
    assign old_sq     = ring_rdata[brd_pkg::SQ_W-1:0];
    // slots are unwritten until the window has filled once
    assign old_tag    = (fill_reg == CW'(WINDOW_SIZE))
                      ? brd_pkg::tag_t'(ring_rdata[brd_pkg::SQ_W+1:brd_pkg::SQ_W])
                      : brd_pkg::TAG_ABSENT;

    brd_ram #(.WIDTH(brd_pkg::SQ_W + 2), .DEPTH(WINDOW_SIZE)) u_sq_ram (
        .clk   (clk),
        .we    (sq_we),
        .addr  (slot_reg),
        .wdata (ring_wdata),
        .rdata (ring_rdata)
    );

    assign q_take    = (state_reg == S_IDLE) && q_valid;
    assign out_load  = (state_reg == S_OUT) && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign up_ok = (fill_reg == CW'(WINDOW_SIZE)) && (pcnt_reg != '0);
    assign lo_ok = (fill_reg == CW'(WINDOW_SIZE)) && (ncnt_reg != '0);
    assign x_s   = 18'(item_reg.sample);
    assign ut_s  = up_ok ? $signed({3'b000, ut_reg}) : 18'sd0;
    assign lt_s  = lo_ok ? -$signed({2'b00, lt_mag_reg}) : 18'sd0;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (q_take) state_next = S_READ;
            S_READ:  state_next = S_UPD;
            S_UPD:   state_next = (fill_reg >= CW'(WINDOW_SIZE - 1)) ? S_DIV : S_MACH;
            S_DIV:   if (step_reg == '0) state_next = S_SQRT;
            S_SQRT:
                if (rbit_reg == '0)
                    state_next = (!pass_reg && lo_ok) ? S_DIV : S_MACH;
            S_MACH:  state_next = S_RATE;
            S_RATE:  if (!breath_reg || step_reg == '0) state_next = S_OUT;
            S_OUT:   if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            item_reg <= q_item;
            sq_reg   <= brd_pkg::SQ_W'($signed(32'(q_item.sample))
                                       * $signed(32'(q_item.sample)));
        end
    end

    logic [DVW:0] trial;
    assign trial = {rem_reg, num_reg[DVW-1]} - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            slot_reg      <= '0;
            fill_reg      <= '0;
            psum_reg      <= '0;
            nsum_reg      <= '0;
            pcnt_reg      <= '0;
            ncnt_reg      <= '0;
            band_reg      <= brd_pkg::ST_UNKNOWN;
            ssb_reg       <= '0;
            trusted_reg   <= 1'b0;
            rate_reg      <= '0;
            rate_ok_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            breath_reg    <= 1'b0;
            pass_reg      <= 1'b0;
            ut_reg        <= '0;
            lt_mag_reg    <= '0;
            num_reg       <= '0;
            den_reg       <= '0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            step_reg      <= '0;
            rv_reg        <= '0;
            rres_reg      <= '0;
            rbit_reg      <= '0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_UPD:
                begin
                    // retire the oldest entry, add the new one
                    logic [SW-1:0] ps, ns;
                    logic [CW-1:0] pc, nc;
                    ps = psum_reg; ns = nsum_reg; pc = pcnt_reg; nc = ncnt_reg;
                    if (old_tag == brd_pkg::TAG_POS)
                    begin
                        ps = ps - SW'(old_sq); pc = pc - 1'b1;
                    end
                    else if (old_tag == brd_pkg::TAG_NEG)
                    begin
                        ns = ns - SW'(old_sq); nc = nc - 1'b1;
                    end
                    if (new_tag == brd_pkg::TAG_POS)
                    begin
                        ps = ps + SW'(sq_reg); pc = pc + 1'b1;
                    end
                    else if (new_tag == brd_pkg::TAG_NEG)
                    begin
                        ns = ns + SW'(sq_reg); nc = nc + 1'b1;
                    end
                    psum_reg <= ps; nsum_reg <= ns; pcnt_reg <= pc; ncnt_reg <= nc;
                    slot_reg <= (32'(slot_reg) + 1 >= WINDOW_SIZE) ? '0 : slot_reg + 1'b1;
                    if (fill_reg < CW'(WINDOW_SIZE)) fill_reg <= fill_reg + 1'b1;
                    ut_reg     <= '0;
                    lt_mag_reg <= '0;
                    // start the first division
                    if (fill_reg >= CW'(WINDOW_SIZE - 1) && pc != '0)
                    begin
                        pass_reg <= 1'b0;
                        num_reg  <= ps;
                        den_reg  <= DVW'(pc);
                    end
                    else
                    begin
                        pass_reg <= 1'b1;
                        num_reg  <= ns;
                        den_reg  <= DVW'(nc);
                    end
                    rem_reg  <= '0;
                    step_reg <= 6'(DVW);
                end
                S_DIV:
                begin
                    if (step_reg != '0)
                    begin
                        if (!trial[DVW])
                        begin
                            rem_reg <= trial[DVW-1:0];
                            quo_reg <= {quo_reg[DVW-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= {rem_reg[DVW-2:0], num_reg[DVW-1]};
                            quo_reg <= {quo_reg[DVW-2:0], 1'b0};
                        end
                        num_reg  <= {num_reg[DVW-2:0], 1'b0};
                        step_reg <= step_reg - 1'b1;
                    end
                    else
                    begin
                        rv_reg   <= quo_reg[31:0];
                        rres_reg <= '0;
                        rbit_reg <= 32'h4000_0000;
                    end
                end
                S_SQRT:
                begin
                    if (rbit_reg != '0)
                    begin
                        if (rv_reg >= rres_reg + rbit_reg)
                        begin
                            rv_reg   <= rv_reg - (rres_reg + rbit_reg);
                            rres_reg <= (rres_reg >> 1) + rbit_reg;
                        end
                        else
                        begin
                            rres_reg <= rres_reg >> 1;
                        end
                        rbit_reg <= rbit_reg >> 2;
                    end
                    else
                    begin
                        if (!pass_reg) ut_reg <= rres_reg[14:0];
                        else lt_mag_reg <= rres_reg[15:0];
                        if (!pass_reg && lo_ok)
                        begin
                            pass_reg <= 1'b1;
                            num_reg  <= nsum_reg;
                            den_reg  <= DVW'(ncnt_reg);
                            rem_reg  <= '0;
                            step_reg <= 6'(DVW);
                        end
                    end
                end
                S_MACH:
                begin
                    brd_pkg::band_t st;
                    logic [brd_pkg::SSB_W-1:0] ssb;
                    logic br;
                    st = band_reg; br = 1'b0;
                    ssb = (ssb_reg != '1) ? ssb_reg + 1'b1 : ssb_reg;
                    if (!up_ok || !lo_ok || !item_reg.present)
                    begin
                        rate_ok_reg <= 1'b0; trusted_reg <= 1'b0;
                    end
                    else
                    begin
                        if (st == brd_pkg::ST_UNKNOWN)
                        begin
                            if (x_s < lt_s) st = brd_pkg::ST_LOW;
                            else if (x_s > ut_s) st = brd_pkg::ST_HIGH;
                            else st = brd_pkg::ST_MID_UNKNOWN;
                        end
                        if (ut_s - lt_s < $signed({2'b00, min_half_gap, 1'b0}))
                        begin
                            st = brd_pkg::ST_UNKNOWN;
                            rate_ok_reg <= 1'b0; trusted_reg <= 1'b0;
                        end
                        else if (st == brd_pkg::ST_LOW && x_s > lt_s)
                            st = brd_pkg::ST_MID_RISING;
                        else if (st == brd_pkg::ST_HIGH && x_s < ut_s)
                            st = brd_pkg::ST_MID_FALLING;
                        else if ((st == brd_pkg::ST_MID_RISING
                                  || st == brd_pkg::ST_MID_UNKNOWN) && x_s > ut_s)
                            st = brd_pkg::ST_HIGH;
                        else if ((st == brd_pkg::ST_MID_FALLING
                                  || st == brd_pkg::ST_MID_UNKNOWN) && x_s < lt_s)
                        begin
                            st = brd_pkg::ST_LOW;
                            br = 1'b1;
                            // rate division runs on every breath, kept only if count trusted
                            num_reg  <= DVW'(20'(sample_rate_q4) * 20'd240) << (DVW - RW);
                            den_reg  <= DVW'(ssb);
                            rem_reg  <= '0;
                            step_reg <= 6'(RW);
                        end
                    end
                    band_reg <= st;
                    ssb_reg  <= br ? '0 : ssb;
                    breath_reg <= br;
                end
                S_RATE:
                begin
                    if (breath_reg)
                    begin
                        if (step_reg != '0)
                        begin
                            if (!trial[DVW])
                            begin
                                rem_reg <= trial[DVW-1:0];
                                quo_reg <= {quo_reg[DVW-2:0], 1'b1};
                            end
                            else
                            begin
                                rem_reg <= {rem_reg[DVW-2:0], num_reg[DVW-1]};
                                quo_reg <= {quo_reg[DVW-2:0], 1'b0};
                            end
                            num_reg  <= {num_reg[DVW-2:0], 1'b0};
                            step_reg <= step_reg - 1'b1;
                        end
                        else
                        begin
                            if (trusted_reg)
                            begin
                                rate_reg    <= brd_pkg::RATE_W'(quo_reg[RW-1:0]);
                                rate_ok_reg <= 1'b1;
                            end
                            trusted_reg <= 1'b1;
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        res_reg.upper_level     <= up_ok ? ut_reg : '0;
                        res_reg.lower_level     <= lo_ok ? 16'(-$signed({1'b0, lt_mag_reg}))
                                                         : '0;
                        res_reg.upper_present   <= up_ok;
                        res_reg.lower_present   <= lo_ok;
                        res_reg.band_state      <= band_reg;
                        res_reg.rate_bpm        <= rate_ok_reg ? rate_reg : '0;
                        res_reg.rate_present    <= rate_ok_reg;
                        res_reg.breath_detected <= breath_reg;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

[hdl/breathing_rate_detector.sv]
// breathing rate detector top level
// the back end takes one item at a time and finishes it before taking the next; the shared
// 38-step divider and 16-step square root run once per rms level once the window is full,
// and a breath adds a rate division; the result register lets the back end finish the next
// item while a result waits, and a two-entry input queue takes two more
// reset: asynchronous active low, clears window fill, sums, machine state and rate
module breathing_rate_detector #(
    parameter int WINDOW_SIZE = brd_pkg::WINDOW_SIZE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // sample
    input  logic        s_tuser,   // sample_present
    output logic        m_tvalid,
    input  logic        m_tready,
    // upper_level, lower_level, upper_present, lower_present, band_state,
    // rate_bpm, rate_present, breath_detected
    output logic [63:0] m_tdata,
    input  logic        cfg_we,
    input  logic [brd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [brd_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic [brd_pkg::GAP_W-1:0]    gap_reg;
    logic [brd_pkg::RATE_Q_W-1:0] rate_q_reg;
    brd_pkg::work_t   in_item, q_item;
    brd_pkg::result_t res;
    logic q_valid, q_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg    <= brd_pkg::MIN_HALF_GAP_RST;
            rate_q_reg <= brd_pkg::SAMPLE_RATE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                brd_pkg::CFG_MIN_HALF_GAP: gap_reg    <= cfg_data;
                brd_pkg::CFG_SAMPLE_RATE:  rate_q_reg <= cfg_data[brd_pkg::RATE_Q_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_item.sample  = s_tdata;
    assign in_item.present = s_tuser;

    brd_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_item(in_item),
        .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
    );

    brd_back #(.WINDOW_SIZE(WINDOW_SIZE)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_take(q_take), .q_item(q_item),
        .min_half_gap(gap_reg), .sample_rate_q4(rate_q_reg),
        .res_valid(m_tvalid), .res_ready(m_tready), .res(res)
    );

    assign m_tdata = {4'd0, res.breath_detected, res.rate_present, res.rate_bpm,
                      res.band_state, res.lower_present, res.upper_present,
                      res.lower_level, res.upper_level};

endmodule

[hdl/brd_checker.sv]
// port-level checker for the breathing rate detector
`include "assert_macros.svh"

module brd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    `ASSERT_CLK(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid, "result dropped")
    `ASSERT_CLK(a_rate_zero, clk, rst_n, m_tvalid && !m_tdata[58] |-> m_tdata[57:36] == 22'd0, "rate without flag")
    `ASSERT_CLK(a_up_zero, clk, rst_n, m_tvalid && !m_tdata[31] |-> m_tdata[14:0] == 15'd0, "upper without flag")
    `ASSERT_CLK(a_band, clk, rst_n, m_tvalid |-> m_tdata[35:33] <= 3'd5, "bad band")
    `ASSERT_ALWAYS(a_rst, clk, !rst_n |-> !m_tvalid, "valid in reset")

endmodule

bind breathing_rate_detector brd_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
